// ----- src/pli_pkg.sv -----
// Shared types and constants for the positional list block.
// No dependencies; every other file imports this package.
package pli_pkg;

    localparam int DATA_W       = 32;
    localparam int POS_W        = 7;
    localparam int STAT_W       = 2;
    localparam int CNT_W        = 7;
    localparam int DEF_CAPACITY = 64;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_DELETE = 1'b1;

    // Shift command broadcast to every cell; pos is the 0-based slot.
    typedef struct packed {
        logic             ins;
        logic             del;
        logic [POS_W-1:0] pos;
    } t_cmd;

endpackage

// ----- src/pli_cell.sv -----
// One storage cell of the list chain: holds one element and its delete pick.
// Depends on pli_pkg.
module pli_cell
    import pli_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic              i_clk,
    input  t_cmd              i_cmd,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_left,
    input  logic [DATA_W-1:0] i_right,
    output logic [DATA_W-1:0] o_data,
    output logic [DATA_W-1:0] o_pick
);

    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] r_pick;
    logic              w_eq;
    logic              w_above;

    assign w_eq    = 32'(IDX) == 32'(i_cmd.pos);
    assign w_above = 32'(IDX) >  32'(i_cmd.pos);

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (w_eq) begin
                r_data <= i_value;
            end else if (w_above) begin
                r_data <= i_left;
            end
        end else if (i_cmd.del) begin
            if (w_eq || w_above) begin
                r_data <= i_right;
            end
        end
        // capture the old content of the deleted slot, zero elsewhere
        if (i_cmd.del) begin
            r_pick <= w_eq ? r_data : '0;
        end
    end

    assign o_data = r_data;
    assign o_pick = r_pick;

endmodule

// ----- src/pli_or_tree.sv -----
// Registered OR tree that collects the one non-zero pick of the cell row.
// Depends on pli_pkg; one register level per tree level.
module pli_or_tree
    import pli_pkg::*;
#(
    parameter int N = DEF_CAPACITY
) (
    input  logic              i_clk,
    input  logic [DATA_W-1:0] i_leaf [N],
    output logic [DATA_W-1:0] o_root
);

    localparam int LG = $clog2(N);
    localparam int P  = 1 << LG;

    logic [DATA_W-1:0] w_leaf [P];
    logic [DATA_W-1:0] r_node [1:P-1];

    genvar g;
    generate
        for (g = 0; g < P; g++) begin : g_leaf
            if (g < N) begin : g_real
                assign w_leaf[g] = i_leaf[g];
            end else begin : g_pad
                assign w_leaf[g] = '0;
            end
        end

        for (g = 1; g < P; g++) begin : g_node
            if (2 * g >= P) begin : g_bottom
                always_ff @(posedge i_clk) begin
                    r_node[g] <= w_leaf[2*g-P] | w_leaf[2*g+1-P];
                end
            end else begin : g_inner
                always_ff @(posedge i_clk) begin
                    r_node[g] <= r_node[2*g] | r_node[2*g+1];
                end
            end
        end
    endgenerate

    assign o_root = r_node[1];

endmodule

// ----- src/pli_ctrl.sv -----
// Request sequencer: range checks, length, shift commands and the result register.
// Depends on pli_pkg; drives the cell row and reads the OR tree root.
module pli_ctrl
    import pli_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_func,
    input  logic [POS_W-1:0]  i_position,
    input  logic [DATA_W-1:0] i_value,
    output t_cmd              o_cmd,
    output logic [DATA_W-1:0] o_value,
    input  logic [DATA_W-1:0] i_root,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [STAT_W-1:0] o_status,
    output logic [DATA_W-1:0] o_removed_value,
    output logic [CNT_W-1:0]  o_count
);

    localparam int LW  = $clog2(CAPACITY + 1);
    localparam int LG  = $clog2(CAPACITY);
    localparam int CTW = $clog2(LG + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_REDUCE,
        S_PUSH
    } t_state;

    t_state            r_state, n_state;
    logic              r_func;
    logic [POS_W-1:0]  r_pos;
    logic [DATA_W-1:0] r_value;
    logic [LW-1:0]     r_length;
    logic [STAT_W-1:0] r_status;
    logic              r_del_ok;
    logic [CTW-1:0]    r_cnt;
    logic              r_out_valid;
    logic [STAT_W-1:0] r_out_status;
    logic [DATA_W-1:0] r_out_removed;
    logic [CNT_W-1:0]  r_out_count;

    logic              w_beyond;
    logic              w_full;
    logic              w_ins_ok;
    logic              w_del_ok;
    logic [STAT_W-1:0] w_status;
    logic              w_out_free;

    assign w_beyond   = 32'(r_pos) > 32'(r_length);
    assign w_full     = 32'(r_length) >= 32'(CAPACITY);
    assign w_ins_ok   = (r_func == FUNC_INSERT) && !w_beyond && !w_full;
    assign w_del_ok   = (r_func == FUNC_DELETE) && (r_pos != '0) && !w_beyond;
    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        if (r_func == FUNC_DELETE) begin
            w_status = w_del_ok ? ST_DONE : ST_RANGE;
        end else if (w_beyond) begin
            w_status = ST_RANGE;
        end else if (w_full) begin
            w_status = ST_FULL;
        end else begin
            w_status = ST_DONE;
        end
    end

    always_comb begin
        o_cmd.ins = (r_state == S_EXEC) && w_ins_ok;
        o_cmd.del = (r_state == S_EXEC) && w_del_ok;
        o_cmd.pos = (r_func == FUNC_DELETE) ? r_pos - POS_W'(1) : r_pos;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = w_del_ok ? S_REDUCE : S_PUSH;
            end
            S_REDUCE: begin
                if (r_cnt == '0) n_state = S_PUSH;
            end
            S_PUSH: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_length    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_valid) begin
                r_func  <= i_func;
                r_pos   <= i_position;
                r_value <= i_value;
            end
            if (r_state == S_EXEC) begin
                r_status <= w_status;
                r_del_ok <= w_del_ok;
                r_cnt    <= CTW'(LG - 1);
                if (w_ins_ok) begin
                    r_length <= r_length + LW'(1);
                end else if (w_del_ok) begin
                    r_length <= r_length - LW'(1);
                end
            end
            if (r_state == S_REDUCE && r_cnt != '0) begin
                r_cnt <= r_cnt - CTW'(1);
            end
            // load the result once the previous beat has left
            if (r_state == S_PUSH && w_out_free) begin
                r_out_valid   <= 1'b1;
                r_out_status  <= r_status;
                r_out_removed <= r_del_ok ? i_root : '1;
                r_out_count   <= CNT_W'(r_length);
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_value         = r_value;
    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_removed_value = r_out_removed;
    assign o_count         = r_out_count;

endmodule

// ----- src/positional_list_insert_delete_top.sv -----
// An insert or a failed request passes S_IDLE, S_EXEC and S_PUSH; a successful delete
// also passes S_REDUCE while the OR tree gathers the removed element. A new request is
// taken only in S_IDLE, after the previous result is loaded, and a result stalled by
// i_ready low holds the sequencer in S_PUSH.
// Reset (synchronous, active low) empties the list; cell contents are not cleared.
// Depends on pli_pkg, pli_cell, pli_or_tree and pli_ctrl.
module positional_list_insert_delete_top
    import pli_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_func,
    input  logic [POS_W-1:0]         i_position,
    input  logic signed [DATA_W-1:0] i_value,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [STAT_W-1:0]        o_status,
    output logic signed [DATA_W-1:0] o_removed_value,
    output logic [CNT_W-1:0]         o_count
);

    t_cmd              w_cmd;
    logic [DATA_W-1:0] w_value;
    logic [DATA_W-1:0] w_root;
    logic [DATA_W-1:0] w_data [CAPACITY];
    logic [DATA_W-1:0] w_pick [CAPACITY];

    pli_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_func         (i_func),
        .i_position     (i_position),
        .i_value        (i_value),
        .o_cmd          (w_cmd),
        .o_value        (w_value),
        .i_root         (w_root),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_removed_value(o_removed_value),
        .o_count        (o_count)
    );

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_W-1:0] w_left;
            logic [DATA_W-1:0] w_right;
            if (g == 0) begin : g_first
                assign w_left = w_value;
            end else begin : g_mid_l
                assign w_left = w_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign w_right = w_data[g];
            end else begin : g_mid_r
                assign w_right = w_data[g+1];
            end
            pli_cell #(
                .IDX(g)
            ) u_cell (
                .i_clk  (i_clk),
                .i_cmd  (w_cmd),
                .i_value(w_value),
                .i_left (w_left),
                .i_right(w_right),
                .o_data (w_data[g]),
                .o_pick (w_pick[g])
            );
        end
    endgenerate

    pli_or_tree #(
        .N(CAPACITY)
    ) u_tree (
        .i_clk (i_clk),
        .i_leaf(w_pick),
        .o_root(w_root)
    );

endmodule

// ----- src/pli_checker.sv -----
// Port-level checks for the positional list block, bound to its top level.
// Depends on pli_pkg and positional_list_insert_delete_top.
module pli_checker
    import pli_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_valid,
    input logic                     o_ready,
    input logic                     o_valid,
    input logic                     i_ready,
    input logic [STAT_W-1:0]        o_status,
    input logic signed [DATA_W-1:0] o_removed_value,
    input logic [CNT_W-1:0]         o_count
);

    // one request in flight: no new beat right after an accepted one
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input taken again right after a beat");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status)
            && $stable(o_removed_value) && $stable(o_count)))
        else $error("stalled result changed");

    a_fail_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_DONE) |-> (o_removed_value == '1))
        else $error("failed request returned a value");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_count == CNT_W'(CAPACITY)))
        else $error("full status with list not full");

endmodule

bind positional_list_insert_delete_top pli_checker #(
    .CAPACITY(CAPACITY)
) u_pli_checker (.*);
